@@ design/dlf_pkg.sv @@
// Shared types and constants for the dense layer block.
`timescale 1ns / 1ps
package dlf_pkg;

    localparam logic [1:0] REQ_WEIGHT = 2'd0;
    localparam logic [1:0] REQ_BIAS   = 2'd1;
    localparam logic [1:0] REQ_ELEM   = 2'd2;

    localparam logic [1:0] ACT_LINEAR  = 2'd0;
    localparam logic [1:0] ACT_SIGMOID = 2'd1;
    localparam logic [1:0] ACT_TANH    = 2'd2;
    localparam logic [1:0] ACT_RELU    = 2'd3;

    localparam logic [1:0] CFG_ACT  = 2'd0;
    localparam logic [1:0] CFG_NIN  = 2'd1;
    localparam logic [1:0] CFG_NN   = 2'd2;

    localparam int ACC_BITS   = 40;
    localparam int VALUE_BITS = 16;

    typedef struct packed {
        logic [1:0]                   req_type;
        logic [4:0]                   neuron_sel;
        logic [5:0]                   element_pos;
        logic signed [VALUE_BITS-1:0] data_value;
        logic                         vector_end;
    } in_word_t;

    typedef struct packed {
        logic [4:0]                   neuron_id;
        logic signed [VALUE_BITS-1:0] activation_out;
        logic                         final_result;
    } out_word_t;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic load;
        logic acc;
        logic shift;
    } cell_ctl_t;

    // tanh knots at steps of 0.25, scaled by 256
    function automatic logic [8:0] tanh_knot(input logic [4:0] k);
        logic [8:0] r;
        begin
            case (k)
                5'd0:  r = 9'd0;
                5'd1:  r = 9'd63;
                5'd2:  r = 9'd118;
                5'd3:  r = 9'd163;
                5'd4:  r = 9'd195;
                5'd5:  r = 9'd217;
                5'd6:  r = 9'd232;
                5'd7:  r = 9'd241;
                5'd8:  r = 9'd247;
                5'd9:  r = 9'd250;
                5'd10: r = 9'd253;
                5'd11: r = 9'd254;
                5'd12: r = 9'd255;
                5'd13: r = 9'd255;
                default: r = 9'd256;
            endcase
            return r;
        end
    endfunction

    // Interpolated tanh for a in 0..1024
    function automatic logic [8:0] tanh_pos(input logic [10:0] a);
        logic [4:0]  k;
        logic [5:0]  f;
        logic [8:0]  lo;
        logic [8:0]  hi;
        logic [15:0] d;
        begin
            k  = a[10:6];
            f  = a[5:0];
            lo = tanh_knot(k);
            hi = tanh_knot(k + 5'd1);
            d  = 16'(hi - lo) * 16'(f) + 16'd32;
            if (a >= 11'd1024)
                return 9'd256;
            return lo + 9'(d >> 6);
        end
    endfunction

endpackage

@@ design/dlf_cell.sv @@
// One neuron cell: accumulator with saturation, loads bias or shifts its neighbour's sum.
`timescale 1ns / 1ps
module dlf_cell
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dlf_pkg::cell_ctl_t                   ctl,
    input  logic                                 enable,
    input  logic signed [15:0]                   bias,
    input  logic signed [15:0]                   weight,
    input  logic signed [15:0]                   element,
    input  logic signed [dlf_pkg::ACC_BITS-1:0]  shift_in,
    output logic signed [dlf_pkg::ACC_BITS-1:0]  sum
);

    localparam int AB = dlf_pkg::ACC_BITS;
    localparam logic signed [AB:0] AMAX = {2'b00, {(AB-1){1'b1}}};
    localparam logic signed [AB:0] AMIN = {2'b11, {(AB-1){1'b0}}};

    logic signed [AB-1:0] sum_reg;
    logic signed [AB-1:0] sum_next;
    logic signed [AB-1:0] base;
    logic signed [31:0]   prod;
    logic signed [AB:0]   total;

    // bias in Q24.16 starts the sum on a fresh vector
    always_comb
    begin
        base  = ctl.load ? (AB'(bias) <<< 8) : sum_reg;
        prod  = weight * element;
        total = (AB+1)'(base) + (AB+1)'(prod);
        if (!enable)
            total = (AB+1)'(base);
        sum_next = sum_reg;
        if (ctl.shift)
            sum_next = shift_in;
        else if (ctl.acc)
        begin
            if (total > AMAX)
                sum_next = AMAX[AB-1:0];
            else if (total < AMIN)
                sum_next = AMIN[AB-1:0];
            else
                sum_next = total[AB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_reg <= '0;
        else
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;

endmodule

@@ design/dlf_act.sv @@
// Rounding, saturation and activation for one drained sum.
`timescale 1ns / 1ps
module dlf_act
(
    input  logic [1:0]                          mode,
    input  logic signed [dlf_pkg::ACC_BITS-1:0] sum,
    output logic signed [15:0]                  y
);

    localparam int AB = dlf_pkg::ACC_BITS;

    logic signed [AB:0]  rnd;
    logic signed [AB-8:0] s_wide;
    logic signed [15:0]  s;
    logic [15:0]         a;
    logic [10:0]         at;
    logic [10:0]         ah;
    logic [8:0]          t;
    logic [8:0]          th;
    logic [9:0]          sg;

    always_comb
    begin
        rnd    = (AB+1)'(sum) + (AB+1)'(128);
        s_wide = rnd[AB:8];
        if (s_wide > (AB-7)'(32767))
            s = 16'sd32767;
        else if (s_wide < -(AB-7)'(32768))
            s = -16'sd32768;
        else
            s = s_wide[15:0];
        a  = s[15] ? 16'(-s) : 16'(s);
        at = (a > 16'd1024) ? 11'd1024 : a[10:0];
        ah = (a[15:1] > 15'd1024) ? 11'd1024 : a[11:1];
        t  = dlf_pkg::tanh_pos(at);
        th = dlf_pkg::tanh_pos(ah);
        sg = s[15] ? (10'd257 - 10'(th)) : (10'd257 + 10'(th));
        unique case (mode)
            dlf_pkg::ACT_SIGMOID: y = 16'(sg[9:1]);
            dlf_pkg::ACT_TANH:    y = s[15] ? -16'(t) : 16'(t);
            dlf_pkg::ACT_RELU:    y = s[15] ? 16'sd0 : s;
            default:              y = s;
        endcase
    end

endmodule

@@ design/dense_layer_forward.sv @@
// Top level of the dense layer: stores, cell row and drain sequencer.
`timescale 1ns / 1ps
// Use: words on the in channel write weights (req_type 0), biases (1) or carry
// input elements (2). An element is broadcast to every neuron cell, which adds
// weight times element to its sum; the first element of a vector starts each
// sum at the neuron's bias. Weight and bias reads are registered from memory,
// so an element holds off the next input word while the cells accumulate.
// On an element with vector_end set, the cell row shifts its sums towards the
// output, one neuron per cycle through the activation stage, giving
// neuron_count words on the out channel, the last with final_result set.
// No input word is taken during the drain; a stall on the out channel holds
// the output register and the row shift. The user is to write configuration
// over cfg_valid/cfg_ready only while idle; the block does not enforce this,
// and cfg_ready is always high. Reset clears sums, control and configuration
// to their reset values; weight and bias memories are undefined until
// written.
module dense_layer_forward
#(
    parameter int MAX_NEURONS = 32,
    parameter int MAX_INPUTS  = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dlf_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dlf_pkg::out_word_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [6:0]          cfg_data
);

    localparam int AB = dlf_pkg::ACC_BITS;
    localparam int PB = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    typedef enum logic [1:0] { S_IDLE, S_ACC, S_DRAIN } state_t;

    // configuration
    logic [1:0] mode_reg;
    logic [6:0] nin_reg;
    logic [5:0] nn_reg;
    logic [6:0] nin_c;
    logic [6:0] nn_c;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dlf_pkg::ACT_LINEAR;
            nin_reg  <= 7'd64;
            nn_reg   <= 6'd32;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dlf_pkg::CFG_ACT: mode_reg <= cfg_data[1:0];
                dlf_pkg::CFG_NIN: nin_reg  <= cfg_data;
                dlf_pkg::CFG_NN:  nn_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        nin_c = (nin_reg == 7'd0) ? 7'd1 : nin_reg;
        if (32'(nin_c) > MAX_INPUTS)
            nin_c = 7'(MAX_INPUTS);
        nn_c = (nn_reg == 6'd0) ? 7'd1 : 7'(nn_reg);
        if (32'(nn_c) > MAX_NEURONS)
            nn_c = 7'(MAX_NEURONS);
    end

    // memories: one weight column bank per neuron cell, plus biases
    logic signed [15:0] wmem [MAX_NEURONS][MAX_INPUTS];
    logic signed [15:0] bmem [MAX_NEURONS];
    logic signed [15:0] wrd_reg [MAX_NEURONS];
    logic signed [15:0] brd_reg [MAX_NEURONS];

    state_t state_reg;
    logic   open_reg;
    logic   in_fire;
    logic [PB-1:0] pos_idx;
    logic   pos_ok_reg;
    logic   end_reg;
    logic   load_reg;
    logic signed [15:0] elem_reg;
    logic [6:0] cnt_reg;
    logic [6:0] left_reg;
    logic   ov_reg;
    dlf_pkg::out_word_t od_reg;
    logic   shift_go;
    dlf_pkg::cell_ctl_t ctl;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign pos_idx  = PB'(in_data.element_pos);

    genvar g;
    generate
        for (g = 0; g < MAX_NEURONS; g++)
        begin : g_mem
            always_ff @(posedge clk)
            begin
                if (in_fire && in_data.req_type == dlf_pkg::REQ_WEIGHT
                    && 32'(in_data.neuron_sel) == g
                    && 32'(in_data.element_pos) < MAX_INPUTS)
                    wmem[g][pos_idx] <= in_data.data_value;
                if (in_fire && in_data.req_type == dlf_pkg::REQ_BIAS
                    && 32'(in_data.neuron_sel) == g)
                    bmem[g] <= in_data.data_value;
                wrd_reg[g] <= wmem[g][pos_idx];
                brd_reg[g] <= bmem[g];
            end
        end
    endgenerate

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            open_reg   <= 1'b0;
            pos_ok_reg <= 1'b0;
            end_reg    <= 1'b0;
            load_reg   <= 1'b0;
            cnt_reg    <= '0;
            left_reg   <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                    if (in_fire && in_data.req_type == dlf_pkg::REQ_ELEM)
                    begin
                        state_reg  <= S_ACC;
                        load_reg   <= !open_reg;
                        open_reg   <= !in_data.vector_end;
                        end_reg    <= in_data.vector_end;
                        pos_ok_reg <= (7'(in_data.element_pos) < nin_c);
                    end
                S_ACC:
                begin
                    if (end_reg)
                    begin
                        state_reg <= S_DRAIN;
                        cnt_reg   <= '0;
                        left_reg  <= nn_c;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_DRAIN:
                begin
                    if (shift_go)
                    begin
                        ov_reg   <= 1'b1;
                        cnt_reg  <= cnt_reg + 7'd1;
                        left_reg <= left_reg - 7'd1;
                    end
                    else
                    begin
                        if (out_valid && !out_stall)
                            ov_reg <= 1'b0;
                        if (left_reg == 7'd0 && !(ov_reg && out_stall))
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            elem_reg <= in_data.data_value;
    end

    assign shift_go = (state_reg == S_DRAIN) && (left_reg != 7'd0)
                      && !(ov_reg && out_stall);

    always_comb
    begin
        ctl.load  = load_reg;
        ctl.acc   = (state_reg == S_ACC);
        ctl.shift = shift_go;
    end

    // cell row: sums shift towards cell 0 during the drain
    logic signed [AB-1:0] sums [MAX_NEURONS];
    generate
        for (g = 0; g < MAX_NEURONS; g++)
        begin : g_cell
            logic signed [AB-1:0] sin;
            if (g == MAX_NEURONS - 1)
            begin : g_tail
                assign sin = '0;
            end
            else
            begin : g_link
                assign sin = sums[g+1];
            end
            dlf_cell u_cell
            (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .enable   (pos_ok_reg && (g < 32'(nn_c))),
                .bias     (brd_reg[g]),
                .weight   (wrd_reg[g]),
                .element  (elem_reg),
                .shift_in (sin),
                .sum      (sums[g])
            );
        end
    endgenerate

    // activation on cell 0 and output register
    logic signed [15:0] act_y;
    dlf_act u_act
    (
        .mode (mode_reg),
        .sum  (sums[0]),
        .y    (act_y)
    );

    always_ff @(posedge clk)
    begin
        if (shift_go)
        begin
            od_reg.neuron_id      <= cnt_reg[4:0];
            od_reg.activation_out <= act_y;
            od_reg.final_result   <= (left_reg == 7'd1);
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

endmodule

@@ bench/dlf_checker.sv @@
// Checker for the dense layer: watches all channels, predicts each neuron word and compares.
`timescale 1ns / 1ps
module dlf_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  dlf_pkg::in_word_t  in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  dlf_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data,
    output int                 fail_count,
    output int                 words_due,
    output int                 words_seen,
    output int                 vectors_seen
);

    localparam longint SUM_MAX = 64'sd549755813887;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // Shadow of the layer state
    logic signed [15:0] weight_mem [32][64];
    logic signed [15:0] bias_mem [32];
    longint             neuron_acc [32];
    bit                 vec_open;
    logic [1:0]         act_mode;
    logic [6:0]         n_inputs;
    logic [5:0]         n_neurons;
    dlf_pkg::out_word_t neuron_words_due [$];

    function automatic int tanh_knot_val(input int k);
        case (k)
            0: return 0;     1: return 63;    2: return 118;   3: return 163;
            4: return 195;   5: return 217;   6: return 232;   7: return 241;
            8: return 247;   9: return 250;   10: return 253;  11: return 254;
            12: return 255;  13: return 255;
            default: return 256;
        endcase
    endfunction

    // Interpolated tanh of a non-negative Q8.8 magnitude
    function automatic int tanh_mag(input int a);
        int k;
        int f;
        int lo;
        if (a >= 1024)
            return 256;
        k  = a >> 6;
        f  = a & 63;
        lo = tanh_knot_val(k);
        return lo + (((tanh_knot_val(k + 1) - lo) * f + 32) >>> 6);
    endfunction

    // Round, saturate and activate one neuron sum
    function automatic logic signed [15:0] neuron_output(input longint acc);
        longint s;
        longint mag;
        int     t;
        s = (acc + 128) >>> 8;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        mag = (s < 0) ? -s : s;
        case (act_mode)
            dlf_pkg::ACT_SIGMOID:
            begin
                t = tanh_mag(int'(((mag >> 1) > 1024) ? 1024 : (mag >> 1)));
                return (s >= 0) ? 16'((256 + t + 1) >> 1) : 16'((256 - t + 1) >> 1);
            end
            dlf_pkg::ACT_TANH:
            begin
                t = tanh_mag(int'((mag > 1024) ? 1024 : mag));
                return (s >= 0) ? 16'(t) : 16'(-t);
            end
            dlf_pkg::ACT_RELU:
                return (s <= 0) ? 16'sd0 : 16'(s);
            default:
                return 16'(s);
        endcase
    endfunction

    // Apply one accepted input word to the shadow state
    task automatic apply_word(input dlf_pkg::in_word_t w);
        int                 nin;
        int                 nn;
        longint             sum;
        dlf_pkg::out_word_t r;
        nin = (n_inputs < 1) ? 1 : ((n_inputs > 64) ? 64 : int'(n_inputs));
        nn  = (n_neurons < 1) ? 1 : ((n_neurons > 32) ? 32 : int'(n_neurons));
        case (w.req_type)
            dlf_pkg::REQ_WEIGHT:
                weight_mem[w.neuron_sel][w.element_pos] = w.data_value;
            dlf_pkg::REQ_BIAS:
                bias_mem[w.neuron_sel] = w.data_value;
            dlf_pkg::REQ_ELEM:
            begin
                if (!vec_open)
                begin
                    for (int n = 0; n < 32; n++)
                        neuron_acc[n] = longint'(bias_mem[n]) * 256;
                    vec_open = 1;
                end
                if (w.element_pos < nin)
                begin
                    for (int n = 0; n < nn; n++)
                    begin
                        sum = neuron_acc[n]
                            + longint'(weight_mem[n][w.element_pos]) * longint'(w.data_value);
                        neuron_acc[n] = (sum > SUM_MAX) ? SUM_MAX
                                      : ((sum < SUM_MIN) ? SUM_MIN : sum);
                    end
                end
                if (w.vector_end)
                begin
                    vec_open = 0;
                    vectors_seen++;
                    for (int n = 0; n < nn; n++)
                    begin
                        r.neuron_id      = 5'(n);
                        r.activation_out = neuron_output(neuron_acc[n]);
                        r.final_result   = (n + 1 == nn);
                        neuron_words_due.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vec_open     = 0;
            act_mode     = dlf_pkg::ACT_LINEAR;
            n_inputs     = 7'd64;
            n_neurons    = 6'd32;
            fail_count   = 0;
            words_seen   = 0;
            vectors_seen = 0;
            neuron_words_due.delete();
            for (int n = 0; n < 32; n++)
                neuron_acc[n] = 0;
        end
        else
        begin
            // compare an accepted output word with the oldest prediction
            if (out_valid && !out_stall)
            begin
                words_seen++;
                if (neuron_words_due.size() == 0)
                begin
                    $error("unexpected output word %p", out_data);
                    fail_count++;
                end
                else
                begin
                    dlf_pkg::out_word_t e;
                    e = neuron_words_due.pop_front();
                    if (out_data.neuron_id !== e.neuron_id)
                    begin
                        $error("neuron_id: expected %0d, got %0d", e.neuron_id,
                               out_data.neuron_id);
                        fail_count++;
                    end
                    if (out_data.activation_out !== e.activation_out)
                    begin
                        $error("activation_out: expected %0d, got %0d",
                               e.activation_out, out_data.activation_out);
                        fail_count++;
                    end
                    if (out_data.final_result !== e.final_result)
                    begin
                        $error("final_result: expected %0d, got %0d",
                               e.final_result, out_data.final_result);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_word(in_data);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dlf_pkg::CFG_ACT: act_mode  = cfg_data[1:0];
                    dlf_pkg::CFG_NIN: n_inputs  = cfg_data;
                    dlf_pkg::CFG_NN:  n_neurons = cfg_data[5:0];
                    default: ;
                endcase
            end
        end
        words_due = neuron_words_due.size();
    end

endmodule

@@ bench/tb_dense_layer_forward.sv @@
// Stimulus and verdict for the dense layer block.
`timescale 1ns / 1ps
module tb_dense_layer_forward;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    dlf_pkg::in_word_t  in_data = '0;
    logic               out_valid;
    logic               out_stall = 0;
    dlf_pkg::out_word_t out_data;
    logic               cfg_valid = 0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [6:0]         cfg_data = '0;

    int fail_count;
    int words_due;
    int words_seen;
    int vectors_seen;
    int cycle_count = 0;
    int items_sent = 0;
    int hold_left = 0;
    bit hold_go = 0;
    bit hold_taken = 0;
    bit calm = 0;

    dense_layer_forward u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dlf_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .words_due    (words_due),
        .words_seen   (words_seen),
        .vectors_seen (vectors_seen)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: random stalls, one long hold-off counted here
    always @(posedge clk)
    begin
        if (hold_go && !hold_taken)
        begin
            hold_taken <= 1;
            hold_left  <= 400;
            out_stall  <= 1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1;
        end
        else
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
    end

    // Offer one word and wait for it to be taken; valid stays high afterwards
    task automatic send_word(input logic [1:0] req, input int nsel, input int pos,
                             input logic [15:0] val, input bit last);
        dlf_pkg::in_word_t w;
        w.req_type    = req;
        w.neuron_sel  = 5'(nsel);
        w.element_pos = 6'(pos);
        w.data_value  = val;
        w.vector_end  = last;
        while (!calm && $urandom_range(99) < 34)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Wait until every predicted word has arrived and the drain has settled
    task automatic settle();
        in_valid <= 0;
        @(posedge clk);
        while (words_due != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= 7'(val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 0;
    endtask

    // Mostly small values so the curved activations are exercised
    function automatic logic [15:0] pick_value();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1024) - 512);
            default: return 16'($urandom_range(256) - 128);
        endcase
    endfunction

    // One input vector with random content and stray writes in between
    task automatic send_vector(input int len);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(19))
                0: send_word(dlf_pkg::REQ_WEIGHT, $urandom_range(31), $urandom_range(7),
                             pick_value(), 1'($urandom_range(1)));
                1: send_word(dlf_pkg::REQ_BIAS, $urandom_range(31), $urandom_range(63),
                             pick_value(), 1'($urandom_range(1)));
                2: send_word(2'd3, $urandom_range(31), $urandom_range(63),
                             16'($urandom), 1'($urandom_range(1)));
                default: ;
            endcase
            send_word(dlf_pkg::REQ_ELEM, $urandom_range(31), $urandom_range(7),
                      pick_value(), i == len - 1);
        end
    endtask

    initial
    begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        repeat (2) @(posedge clk);

        // Fill every bias and the weight columns that elements use
        for (int n = 0; n < 32; n++)
            send_word(dlf_pkg::REQ_BIAS, n, $urandom_range(63), pick_value(), 0);
        for (int n = 0; n < 32; n++)
            for (int p = 0; p < 8; p++)
                send_word(dlf_pkg::REQ_WEIGHT, n, p, pick_value(), 0);
        settle();

        // Directed: saturation, ignored words, out-of-use positions, late bias
        write_reg(dlf_pkg::CFG_ACT, dlf_pkg::ACT_LINEAR);
        write_reg(dlf_pkg::CFG_NIN, 6);
        write_reg(dlf_pkg::CFG_NN, 4);
        send_word(dlf_pkg::REQ_WEIGHT, 0, 0, 16'h8000, 1);
        send_word(dlf_pkg::REQ_WEIGHT, 1, 0, 16'h7fff, 0);
        send_word(dlf_pkg::REQ_WEIGHT, 2, 0, 16'h0000, 0);
        send_word(dlf_pkg::REQ_WEIGHT, 31, 63, 16'h7fff, 1);
        send_word(dlf_pkg::REQ_ELEM, 0, 0, 16'h8000, 0);
        send_word(dlf_pkg::REQ_ELEM, 31, 0, 16'h7fff, 1);
        send_word(2'd3, 31, 63, 16'hffff, 1);
        send_word(dlf_pkg::REQ_ELEM, 0, 7, 16'h7fff, 0);
        send_word(dlf_pkg::REQ_BIAS, 3, 0, 16'h7fff, 1);
        send_word(dlf_pkg::REQ_ELEM, 0, 1, 16'h0100, 0);
        send_word(dlf_pkg::REQ_ELEM, 0, 6, 16'h0100, 1);
        send_word(dlf_pkg::REQ_ELEM, 0, 0, 16'h0000, 1);
        settle();

        // Random phases across activation modes and counts, clamps included
        phase = 0;
        while (phase < 6 || items_sent < 400)
        begin
            case (phase)
                0: begin write_reg(dlf_pkg::CFG_ACT, dlf_pkg::ACT_LINEAR);
                         write_reg(dlf_pkg::CFG_NIN, 64);
                         write_reg(dlf_pkg::CFG_NN, 32); end
                1: begin write_reg(dlf_pkg::CFG_ACT, dlf_pkg::ACT_SIGMOID);
                         write_reg(dlf_pkg::CFG_NIN, 1);
                         write_reg(dlf_pkg::CFG_NN, 1); end
                2: begin write_reg(dlf_pkg::CFG_ACT, dlf_pkg::ACT_TANH);
                         write_reg(dlf_pkg::CFG_NIN, 0);
                         write_reg(dlf_pkg::CFG_NN, 0); end
                3: begin write_reg(dlf_pkg::CFG_ACT, dlf_pkg::ACT_RELU);
                         write_reg(dlf_pkg::CFG_NIN, 127);
                         write_reg(dlf_pkg::CFG_NN, 63); end
                default:
                begin
                    write_reg(dlf_pkg::CFG_ACT, $urandom_range(3));
                    write_reg(dlf_pkg::CFG_NIN, $urandom_range(8, 1));
                    write_reg(dlf_pkg::CFG_NN, $urandom_range(32, 1));
                end
            endcase
            calm = (phase == 4);
            for (int v = 0; v < 3; v++)
            begin
                if (phase == 5 && v == 1)
                    hold_go = 1;
                send_vector($urandom_range(10, 1));
            end
            settle();
            phase++;
        end
        calm = 0;
        settle();

        $display("covered %0d words offered, %0d vectors, %0d neuron words checked",
                 items_sent, vectors_seen, words_seen);
        $display("four activation modes, count clamps, saturation and ignored words");
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
